// File: hw/rtl/glla_pkg.sv
`default_nettype none

package glla_pkg;

    // Fraction bits of the fixed point data and results
    localparam int FRAC_BITS = 24;

    // ln(2) in Q4.28
    localparam logic signed [32:0] LN2_Q28 = 33'sd186065279;

    // 0.5*ln(2*pi) rounded half up to FRAC_BITS fraction bits
    localparam logic signed [50:0] HALF_LN_2PI = 51'sd15417230;

    localparam logic signed [50:0] ACC_MAX = 51'sd140737488355327;
    localparam logic signed [50:0] ACC_MIN = -51'sd140737488355328;

    typedef logic signed [32:0] mul_op_t;
    typedef logic signed [65:0] mul_prod_t;

    // Divider handshake with the sequencer
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [30:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/glla_mul.sv
`default_nettype none

module glla_mul (
    input  wire logic               clk,
    input  wire glla_pkg::mul_op_t   a,
    input  wire glla_pkg::mul_op_t   b,
    output glla_pkg::mul_prod_t      prod_reg
);
    import glla_pkg::*;

    // Register the product, one multiply per cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

`default_nettype wire

// File: hw/rtl/glla_div.sv
`default_nettype none

module glla_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire glla_pkg::div_req_t  req,
    output glla_pkg::div_rsp_t       rsp
);
    import glla_pkg::*;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [30:0] rem_reg;
    logic [30:0] dsr_reg;
    logic [63:0] dvd_reg;
    logic        done_reg;
    logic [31:0] trial;
    logic        fits;

    // One restoring step: shift in the next dividend bit, try to subtract
    assign trial = {rem_reg, dvd_reg[63]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient bits fill the dividend register from the bottom
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dsr_reg <= req.divisor;
            dvd_reg <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 31'(trial - {1'b0, dsr_reg}) : trial[30:0];
            dvd_reg <= {dvd_reg[62:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dvd_reg;

endmodule

`default_nettype wire

// File: hw/rtl/gaussian_log_likelihood_accumulate.sv
// Gaussian log likelihood accumulator for a straight line model.
// Input stream: one data point per word. s_tdata holds x, observed value and
// standard error (signed Q8.24 each); s_tlast marks the last point of a set.
// Output stream: one word per set, sent after its last point: m_tdata holds
// the Q24.24 saturating sum, m_tuser the saturated and bad-error flags.
// Configuration: cfg_we writes slope (index 0) or intercept (index 1).
// One point is processed at a time. A valid point passes through the
// prediction multiply, the bit-serial 64-bit divider, the residual square,
// the 24 log2 squaring steps on the shared multiplier, ln scaling and the
// accumulate, then finish and back to idle; an overflowing quotient or
// square saturates the sum and skips to finish. A point whose error is zero
// or negative goes straight to finish. s_tready is high only between points.
// For the last point of a set, the finish state loads the result into the
// output register, which drives m_tvalid.
// A finished sum waits in the output register; the next set is processed
// meanwhile and only its own result stalls while m_tready stays low.
// Reset clears the sum and flags and sets slope to 1.0, intercept to 0.
`default_nettype none

module gaussian_log_likelihood_accumulate (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // point_x, point_value, point_error
    input  wire logic        s_tlast,   // last_point
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // log_likelihood
    output logic [1:0]       m_tuser,   // saturated, bad_error_seen
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    import glla_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PRED = 4'd1;
    localparam logic [3:0] ST_DIFF = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_SQ0  = 4'd4;
    localparam logic [3:0] ST_SQ1  = 4'd5;
    localparam logic [3:0] ST_SQ2  = 4'd6;
    localparam logic [3:0] ST_SQ3  = 4'd7;
    localparam logic [3:0] ST_SQ4  = 4'd8;
    localparam logic [3:0] ST_LOG  = 4'd9;
    localparam logic [3:0] ST_LOGW = 4'd10;
    localparam logic [3:0] ST_LN   = 4'd11;
    localparam logic [3:0] ST_ACC  = 4'd12;
    localparam logic [3:0] ST_FIN  = 4'd13;

    localparam logic REG_SLOPE     = 1'b0;
    localparam logic REG_INTERCEPT = 1'b1;

    logic [3:0]         state_reg, state_next;
    logic signed [31:0] slope_reg, intercept_reg;
    logic signed [31:0] x_reg, value_reg;
    logic [30:0]        err_reg;
    logic               last_reg;
    logic signed [47:0] acc_reg, acc_next;
    logic               sat_reg, sat_next;
    logic               bad_reg, bad_next;
    logic [74:0]        sq_reg, sq_next;
    logic [36:0]        q_reg, q_next;
    logic [47:0]        hs_reg, hs_next;
    logic [30:0]        m_reg, m_next;
    logic [4:0]         p_reg, p_next;
    logic [23:0]        frac_reg, frac_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [47:0]        out_data_reg, out_data_next;
    logic [1:0]         out_user_reg, out_user_next;

    mul_op_t            mul_a, mul_b;
    mul_prod_t          prod;
    div_req_t           dreq;
    div_rsp_t           drsp;

    logic signed [42:0] pred;
    logic signed [43:0] diff;
    logic [43:0]        mag;
    logic [31:0]        sq_step;
    logic [5:0]         pm24;
    logic signed [29:0] log2v;
    logic signed [65:0] ln_round;
    logic signed [50:0] sum;
    logic               s_acc;
    logic               out_load;

    glla_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    glla_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // Prediction, residual and log2 operand arithmetic
    assign pred     = 43'($signed(prod[65:FRAC_BITS])) + 43'(intercept_reg);
    assign diff     = 44'(pred) - 44'(value_reg);
    assign mag      = diff[43] ? 44'(-diff) : 44'(diff);
    assign sq_step  = prod[61:30];
    assign pm24     = {1'b0, p_reg} - 6'd24;
    assign log2v    = $signed({pm24, frac_reg});
    assign ln_round = prod + (66'sd1 <<< 27);
    assign sum      = 51'(acc_reg) - $signed({3'b0, hs_reg})
                      - 51'($signed(ln_round[65:28])) - HALF_LN_2PI;

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PRED:
            begin
                mul_a = 33'(slope_reg);
                mul_b = 33'(x_reg);
            end
            ST_SQ0:
            begin
                mul_a = $signed({1'b0, q_reg[31:0]});
                mul_b = $signed({1'b0, q_reg[31:0]});
            end
            ST_SQ1:
            begin
                mul_a = $signed({28'b0, q_reg[36:32]});
                mul_b = $signed({1'b0, q_reg[31:0]});
            end
            ST_SQ2:
            begin
                mul_a = $signed({28'b0, q_reg[36:32]});
                mul_b = $signed({28'b0, q_reg[36:32]});
            end
            ST_LOG:
            begin
                mul_a = $signed({2'b0, m_reg});
                mul_b = $signed({2'b0, m_reg});
            end
            ST_LN:
            begin
                mul_a = 33'(log2v);
                mul_b = LN2_Q28;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign dreq.start    = (state_reg == ST_DIFF);
    assign dreq.dividend = {mag[39:0], 24'b0};
    assign dreq.divisor  = err_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        sat_next       = sat_reg;
        bad_next       = bad_reg;
        sq_next        = sq_reg;
        q_next         = q_reg;
        hs_next        = hs_reg;
        m_next         = m_reg;
        p_next         = p_reg;
        frac_next      = frac_reg;
        cnt_next       = cnt_reg;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    if ($signed(s_tdata[95:64]) <= 32'sd0)
                    begin
                        bad_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_PRED;
                    end
                end
            end
            ST_PRED: state_next = ST_DIFF;
            ST_DIFF:
            begin
                m_next     = err_reg;
                p_next     = 5'd30;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // Normalize the error while the divider runs
                if (!m_reg[30])
                begin
                    m_next = {m_reg[29:0], 1'b0};
                    p_next = p_reg - 5'd1;
                end
                if (drsp.done)
                begin
                    if (drsp.quot[63:37] != '0)
                    begin
                        acc_next   = 48'(ACC_MIN);
                        sat_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        q_next     = drsp.quot[36:0];
                        state_next = ST_SQ0;
                    end
                end
            end
            ST_SQ0: state_next = ST_SQ1;
            ST_SQ1:
            begin
                sq_next    = {11'b0, prod[63:0]};
                state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                sq_next    = sq_reg + {prod[41:0], 33'b0};
                state_next = ST_SQ3;
            end
            ST_SQ3:
            begin
                sq_next    = sq_reg + {prod[10:0], 64'b0};
                state_next = ST_SQ4;
            end
            ST_SQ4:
            begin
                if (sq_reg[74:73] != 2'b0)
                begin
                    acc_next   = 48'(ACC_MIN);
                    sat_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    hs_next    = sq_reg[72:25];
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_LOG;
                end
            end
            ST_LOG: state_next = ST_LOGW;
            ST_LOGW:
            begin
                // One fraction bit of log2 per squaring
                frac_next = {frac_reg[22:0], sq_step[31]};
                m_next    = sq_step[31] ? sq_step[31:1] : sq_step[30:0];
                cnt_next  = cnt_reg + 5'd1;
                state_next = (cnt_reg == 5'(FRAC_BITS - 1)) ? ST_LN : ST_LOG;
            end
            ST_LN: state_next = ST_ACC;
            ST_ACC:
            begin
                if (sum > ACC_MAX)
                begin
                    acc_next = 48'(ACC_MAX);
                    sat_next = 1'b1;
                end
                else if (sum < ACC_MIN)
                begin
                    acc_next = 48'(ACC_MIN);
                    sat_next = 1'b1;
                end
                else
                begin
                    acc_next = 48'(sum);
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    acc_next   = '0;
                    sat_next   = 1'b0;
                    bad_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = acc_reg;
            out_user_next  = {bad_reg, sat_reg};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slope_reg     <= 32'sd16777216;
            intercept_reg <= '0;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SLOPE:     slope_reg     <= cfg_data;
                    REG_INTERCEPT: intercept_reg <= cfg_data;
                    default:       slope_reg     <= slope_reg;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            x_reg     <= s_tdata[31:0];
            value_reg <= s_tdata[63:32];
            err_reg   <= s_tdata[94:64];
            last_reg  <= s_tlast;
        end
        sq_reg       <= sq_next;
        q_reg        <= q_next;
        hs_reg       <= hs_next;
        m_reg        <= m_next;
        p_reg        <= p_next;
        frac_reg     <= frac_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

// File: hw/rtl/glla_chk.sv
`default_nettype none

module glla_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Busy after a word is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

    // A new result only comes out of a busy sequencer
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a processed point");

endmodule

bind gaussian_log_likelihood_accumulate glla_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
